[rtl/ius_pkg.sv]
`timescale 1ns / 1ps

package ius_pkg;

	localparam int CFG_DATA_BITS = 13;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_PAIRS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_ROWS = 2'd1;

	localparam logic [CFG_DATA_BITS-1:0] LINE_PAIRS_RESET = 13'd960;
	localparam logic [CFG_DATA_BITS-1:0] FRAME_ROWS_RESET = 13'd1080;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] cb_near;
		logic [7:0] cr_near;
		logic [7:0] cb_far;
		logic [7:0] cr_far;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_luma_first;
		logic [7:0] out_cb;
		logic [7:0] out_luma_second;
		logic [7:0] out_cr;
		logic       row_end;
		logic       frame_end;
	} out_item_t;

	// Per-item position info handed from the counters to the datapath.
	typedef struct packed {
		logic       copy_chroma;
		logic [1:0] phase;
		logic       row_end;
		logic       frame_end;
	} pos_t;

	// Near-line weight for each phase; the far weight is eight minus this.
	function automatic logic [3:0] near_weight(input logic [1:0] phase);
		logic [3:0] w;
		case (phase)
			2'd0: w = 4'd5;
			2'd1: w = 4'd7;
			2'd2: w = 4'd1;
			2'd3: w = 4'd3;
			default: w = 4'd5;
		endcase
		return w;
	endfunction

endpackage

[rtl/interlaced_420_to_422_upsampler_unit.sv]
`timescale 1ns / 1ps

// Interlaced 4:2:0 to 4:2:2 chroma upsampler with packed YUY2 output.
// Each input transaction carries one luma pair plus the Cb/Cr pairs of the
// near chroma line and of the line two chroma lines below it in the same
// field. Each produces exactly one output transaction: Y0, Cb, Y1, Cr with
// row_end and frame_end flags derived from internal column and row counters.
// Configuration writes (index 0 line_pairs, index 1 frame_rows) are always
// accepted and take effect on the next input transaction; other indexes are
// ignored. Write them only while the block is idle.
// The result is registered: out_valid rises the cycle after acceptance. One
// item per cycle is accepted while out_ready is high; the limit is the single
// result register. When the receiver stalls, the result register holds and
// in_ready drops until the result is taken; no data is lost.
// Reset clears the counters and the result valid flag and restores
// line_pairs to 960 and frame_rows to 1080.
module interlaced_420_to_422_upsampler_unit #(
	parameter int COUNT_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ius_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ius_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ius_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ius_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import ius_pkg::*;

	logic [CFG_DATA_BITS-1:0] line_pairs_q;
	logic [CFG_DATA_BITS-1:0] frame_rows_q;
	logic                     valid_s1;
	out_item_t                result_s1;
	out_item_t                result;
	pos_t                     pos;
	logic                     accept;

	assign cfg_ready = 1'b1;
	assign in_ready = !valid_s1 || out_ready;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pairs_q <= LINE_PAIRS_RESET;
			frame_rows_q <= FRAME_ROWS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LINE_PAIRS: line_pairs_q <= cfg_data;
				CFG_FRAME_ROWS: frame_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ius_position #(
		.COUNT_BITS(COUNT_BITS)
	) u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.line_pairs(line_pairs_q),
		.frame_rows(frame_rows_q),
		.pos       (pos)
	);

	ius_blend u_blend_cb (
		.copy_chroma(pos.copy_chroma),
		.phase      (pos.phase),
		.near_sample(in_data.cb_near),
		.far_sample (in_data.cb_far),
		.result     (result.out_cb)
	);

	ius_blend u_blend_cr (
		.copy_chroma(pos.copy_chroma),
		.phase      (pos.phase),
		.near_sample(in_data.cr_near),
		.far_sample (in_data.cr_far),
		.result     (result.out_cr)
	);

	assign result.out_luma_first = in_data.luma_first;
	assign result.out_luma_second = in_data.luma_second;
	assign result.row_end = pos.row_end;
	assign result.frame_end = pos.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= result;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = result_s1;

endmodule

[rtl/ius_position.sv]
`timescale 1ns / 1ps

module ius_position #(
	parameter int COUNT_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [ius_pkg::CFG_DATA_BITS-1:0] line_pairs,
	input  logic [ius_pkg::CFG_DATA_BITS-1:0] frame_rows,
	output ius_pkg::pos_t                     pos
);
	import ius_pkg::*;

	localparam int LW = (COUNT_BITS + 1 > CFG_DATA_BITS) ? COUNT_BITS + 1 : CFG_DATA_BITS;

	logic [COUNT_BITS-1:0] col_q;
	logic [COUNT_BITS-1:0] row_q;
	logic [LW-1:0] cap;
	logic [LW-1:0] lp_ext;
	logic [LW-1:0] fr_ext;
	logic [LW-1:0] lp_eff;
	logic [LW-1:0] fr_eff;
	logic [LW-1:0] col_inc;
	logic [LW-1:0] row_inc;
	logic [LW-1:0] row_ext;
	logic          last_col;
	logic          last_row;

	assign cap = LW'(1) << COUNT_BITS;
	assign lp_ext = LW'(line_pairs);
	assign fr_ext = LW'(frame_rows);

	// A zero limit behaves as one, and a limit beyond the counter range saturates.
	assign lp_eff = (lp_ext == '0) ? LW'(1) : ((lp_ext > cap) ? cap : lp_ext);
	assign fr_eff = (fr_ext == '0) ? LW'(1) : ((fr_ext > cap) ? cap : fr_ext);

	assign row_ext = LW'(row_q);
	assign col_inc = LW'(col_q) + LW'(1);
	assign row_inc = row_ext + LW'(1);

	assign last_col = (col_inc >= lp_eff);
	assign last_row = (row_inc >= fr_eff);

	assign pos.copy_chroma = (row_ext < LW'(2)) || ((row_ext + LW'(2)) >= fr_eff);
	// Phase is (row - 2) mod 4, which only flips bit one of the row.
	assign pos.phase = row_q[1:0] ^ 2'b10;
	assign pos.row_end = last_col;
	assign pos.frame_end = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[COUNT_BITS-1:0];
			end else begin
				col_q <= col_inc[COUNT_BITS-1:0];
			end
		end
	end

endmodule

[rtl/ius_blend.sv]
`timescale 1ns / 1ps

module ius_blend (
	input  logic       copy_chroma,
	input  logic [1:0] phase,
	input  logic [7:0] near_sample,
	input  logic [7:0] far_sample,
	output logic [7:0] result
);
	import ius_pkg::*;

	logic [3:0]  w_near;
	logic [3:0]  w_far;
	logic [11:0] sum;

	assign w_near = near_weight(phase);
	assign w_far = 4'd8 - w_near;

	// The weights add to eight, so the rounded sum always fits in eight bits.
	assign sum = 12'(w_near) * 12'(near_sample) + 12'(w_far) * 12'(far_sample) + 12'd4;
	assign result = copy_chroma ? near_sample : sum[10:3];

endmodule

[dv/ius_checker.sv]
`timescale 1ns / 1ps

module ius_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  ius_pkg::in_item_t                  in_data,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  ius_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [ius_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ius_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 mismatches,
	output int                                 outstanding
);
	import ius_pkg::*;

	localparam int COUNT_BITS = 12;
	localparam int COUNT_LIMIT = 1 << COUNT_BITS;
	localparam logic [CFG_DATA_BITS-1:0] PAIRS_AFTER_RESET = 13'd960;
	localparam logic [CFG_DATA_BITS-1:0] ROWS_AFTER_RESET = 13'd1080;

	logic [CFG_DATA_BITS-1:0] line_pairs_reg;
	logic [CFG_DATA_BITS-1:0] frame_rows_reg;
	logic [COUNT_BITS-1:0]    column_pos;
	logic [COUNT_BITS-1:0]    row_pos;
	out_item_t                expected_pairs[$];
	int                       error_total;

	// A zero register acts as one; anything past the counter range saturates.
	function automatic int clamp_limit(input logic [CFG_DATA_BITS-1:0] value);
		if (value == '0)
			return 1;
		if (int'(value) > COUNT_LIMIT)
			return COUNT_LIMIT;
		return int'(value);
	endfunction

	function automatic logic [7:0] blend_chroma(input logic [7:0] near_sample,
			input logic [7:0] far_sample, input logic [1:0] phase);
		int near_w;
		int sum;
		case (phase)
			2'd0: near_w = 5;
			2'd1: near_w = 7;
			2'd2: near_w = 1;
			default: near_w = 3;
		endcase
		sum = near_w * int'(near_sample) + (8 - near_w) * int'(far_sample) + 4;
		return 8'(sum >> 3);
	endfunction

	task automatic predict_yuy2_pair(input in_item_t pair);
		int        pairs_per_row;
		int        rows_per_frame;
		int        row;
		int        col;
		logic      last_col;
		logic      last_row;
		out_item_t result;
		pairs_per_row = clamp_limit(line_pairs_reg);
		rows_per_frame = clamp_limit(frame_rows_reg);
		row = int'(row_pos);
		col = int'(column_pos);
		result.out_luma_first = pair.luma_first;
		result.out_luma_second = pair.luma_second;
		// The two rows at each edge of the frame have no far line to blend with.
		if (row < 2 || row + 2 >= rows_per_frame) begin
			result.out_cb = pair.cb_near;
			result.out_cr = pair.cr_near;
		end else begin
			result.out_cb = blend_chroma(pair.cb_near, pair.cb_far, 2'(row - 2));
			result.out_cr = blend_chroma(pair.cr_near, pair.cr_far, 2'(row - 2));
		end
		last_col = (col + 1 >= pairs_per_row);
		last_row = (row + 1 >= rows_per_frame);
		result.row_end = last_col;
		result.frame_end = last_col && last_row;
		expected_pairs.push_back(result);
		if (last_col) begin
			column_pos = '0;
			row_pos = last_row ? '0 : COUNT_BITS'(row + 1);
		end else begin
			column_pos = COUNT_BITS'(col + 1);
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("t=%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			error_total++;
		end
	endtask

	task automatic compare_pair(input out_item_t got);
		out_item_t want;
		if (expected_pairs.size() == 0) begin
			$display("t=%0t: unexpected output transaction, expected none, actual %h",
				$time, got);
			error_total++;
		end else begin
			want = expected_pairs.pop_front();
			check_field("out_luma_first", want.out_luma_first, got.out_luma_first);
			check_field("out_cb", want.out_cb, got.out_cb);
			check_field("out_luma_second", want.out_luma_second, got.out_luma_second);
			check_field("out_cr", want.out_cr, got.out_cr);
			check_field("row_end", 8'(want.row_end), 8'(got.row_end));
			check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pairs_reg = PAIRS_AFTER_RESET;
			frame_rows_reg = ROWS_AFTER_RESET;
			column_pos = '0;
			row_pos = '0;
			expected_pairs.delete();
			error_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LINE_PAIRS: line_pairs_reg = cfg_data;
					CFG_FRAME_ROWS: frame_rows_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_yuy2_pair(in_data);
			if (out_valid && out_ready)
				compare_pair(out_data);
			mismatches <= error_total;
			outstanding <= expected_pairs.size();
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

	import ius_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_RESERVED_A = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RESERVED_B = 2'd3;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_ITEMS = 1100;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	in_item_t                  in_data;
	logic                      out_valid;
	logic                      out_ready;
	out_item_t                 out_data;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        mismatches;
	int                        outstanding;
	int                        send_quiet;
	int                        recv_quiet;

	interlaced_420_to_422_upsampler_unit DUT (.*);

	ius_checker pair_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// Mostly random waits, with occasional runs of back-to-back transactions.
	function automatic int draw_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	function automatic in_item_t corner_pair(input int k);
		in_item_t p;
		case (k % 6)
			0: p = '0;
			1: p = '1;
			2: p = {8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00};
			3: p = {8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff};
			4: p = {8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa};
			default: p = {8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55};
		endcase
		return p;
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_line_pairs();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'd8191;
			2: return 13'($urandom_range(9, 64));
			default: return 13'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_frame_rows();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'd8191;
			2: return 13'($urandom_range(1, 7));
			default: return 13'(4 * $urandom_range(1, 4));
		endcase
	endfunction

	task automatic send_pair(input in_item_t pair);
		int gap;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pair;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Let every outstanding pair come out before the block is reconfigured.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [CFG_DATA_BITS-1:0] pairs,
			input logic [CFG_DATA_BITS-1:0] rows, input bit poke_reserved);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_LINE_PAIRS;
		cfg_data <= pairs;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_FRAME_ROWS;
		cfg_data <= rows;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (poke_reserved) begin
			cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_RESERVED_A : CFG_RESERVED_B;
			cfg_data <= 13'($urandom);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int sent;
		int burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_quiet = 0;
		recv_quiet = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few pairs under the geometry that reset leaves behind.
		for (int k = 0; k < 4; k++)
			send_pair(corner_pair(k));
		settle();

		// One pair per row walks every phase and both copied edges twice.
		set_geometry(13'd1, 13'd8, 1'b1);
		for (int k = 0; k < 16; k++)
			send_pair(corner_pair(k));
		settle();

		set_geometry('0, '0, 1'b0);
		for (int k = 0; k < 2; k++)
			send_pair(corner_pair(k + 2));
		settle();

		set_geometry(13'd8191, 13'd4097, 1'b1);
		for (int k = 0; k < 3; k++)
			send_pair(corner_pair(k + 3));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			set_geometry(pick_line_pairs(), pick_frame_rows(), $urandom_range(0, 5) == 0);
			burst = $urandom_range(20, 90);
			for (int k = 0; k < burst; k++) begin
				send_pair(in_item_t'(48'({$urandom, $urandom})));
				sent++;
			end
		end
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
